### hdl/uwdf_pkg.sv
// Shared types and constants for the UART register block with four byte rings.
// No dependencies.
package uwdf_pkg;

  typedef enum logic [2:0] {
    OP_BUS_RD  = 3'd0,
    OP_BUS_WR  = 3'd1,
    OP_WRX_PUT = 3'd2,
    OP_SRX_PUT = 3'd3,
    OP_WTX_GET = 3'd4,
    OP_STX_GET = 3'd5
  } op_e;

  localparam int unsigned RING_WRX = 0;
  localparam int unsigned RING_WTX = 1;
  localparam int unsigned RING_SRX = 2;
  localparam int unsigned RING_STX = 3;
  localparam int unsigned RINGS    = 4;

  localparam logic [7:0] ADDR_WIN_LAST = 8'hBF;
  localparam logic [7:0] ADDR_WRX_USED = 8'hC0;
  localparam logic [7:0] ADDR_WTX_FREE = 8'hC1;
  localparam logic [7:0] ADDR_SRX_USED = 8'hC2;
  localparam logic [7:0] ADDR_STX_FREE = 8'hC3;
  localparam logic [7:0] ADDR_CMD      = 8'hC7;
  localparam logic [7:0] ADDR_UART     = 8'hF8;

  localparam logic [2:0] UART_RBR = 3'd0;
  localparam logic [2:0] UART_IIR = 3'd2;
  localparam logic [2:0] UART_LCR = 3'd3;
  localparam logic [2:0] UART_LSR = 3'd5;
  localparam logic [2:0] UART_MSR = 3'd6;

  localparam logic [7:0] COUNT_SAT    = 8'hBF;
  localparam logic [7:0] NO_ANSWER    = 8'hFF;
  localparam logic [7:0] LCR_DLAB     = 8'h80;
  localparam logic [7:0] LSR_THRE     = 8'h60;
  localparam logic [7:0] LSR_ERR      = 8'h0E;
  localparam logic [7:0] LSR_INT_SRC  = 8'h1E;
  localparam logic [7:0] LSR_DR       = 8'h01;
  localparam logic [7:0] MSR_CTS      = 8'h10;
  localparam logic [7:0] MSR_DCTS     = 8'h01;
  localparam logic [7:0] CMD_SET_MASK = 8'hF8;
  localparam logic [7:0] CMD_SET_LYR  = 8'hF0;
  localparam logic [7:0] CMD_QUERY    = 8'hFF;
  localparam logic [7:0] CMD_CLR_MASK = 8'hFC;
  localparam logic [7:0] CMD_CLR_WL   = 8'h00;
  localparam logic [7:0] CMD_CLR_SER  = 8'h04;

  localparam logic [2:0] IID_LINE = 3'd6;
  localparam logic [2:0] IID_DATA = 3'd4;
  localparam logic [2:0] IID_THRE = 3'd2;
  localparam logic [2:0] IID_NONE = 3'd1;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic       afull;
    logic       multi;
    logic [7:0] used_sat;
    logic [7:0] free_sat;
  } ring_st_t;

endpackage

### hdl/uwdf_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module uwdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### hdl/uart_with_dual_fifo_bridge_registers_top.sv
// Top level: UART register file, command register and four byte rings.
// Depends on uwdf_pkg and uwdf_ram.
// Latency: a request is accepted, executes in the next cycle, and its result
// strobes on done_o in the cycle after that. No new request is taken while busy;
// the block returns to idle first, leaving time for the registered ring RAM read.
// Results cannot be stalled. Reset is asynchronous, active low, and clears
// pointers and registers; ring contents are not cleared.
module uart_with_dual_fifo_bridge_registers_top #(
  parameter int WIRELESS_RX_DEPTH = 256,
  parameter int WIRELESS_TX_DEPTH = 256,
  parameter int SERIAL_RX_DEPTH   = 256,
  parameter int SERIAL_TX_DEPTH   = 256,
  parameter int API_LAYERS        = 1
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] op_i,
  input  logic [7:0] reg_addr_i,
  input  logic [7:0] data_in_i,
  input  logic       cts_level_i,
  output logic       done_o,
  output logic [7:0] read_data_o,
  output logic       tx_valid_o,
  output logic [7:0] tx_byte_o,
  output logic       byte_accepted_o,
  output logic [2:0] interrupt_id_o
);

  typedef enum logic {ST_IDLE, ST_EXEC} st_e;

  localparam int DEPTHS [uwdf_pkg::RINGS] = '{WIRELESS_RX_DEPTH, WIRELESS_TX_DEPTH,
                                              SERIAL_RX_DEPTH, SERIAL_TX_DEPTH};

  st_e        st_q;
  logic [2:0] op_q;
  logic [7:0] addr_q, data_q;
  logic       cts_q;
  logic [7:0] uart_q [8];
  logic [7:0] uart_n [8];
  logic [7:0] dll_q [2];
  logic [7:0] dll_n [2];
  logic [2:0] api_q, api_n;
  logic [7:0] cmd_q, cmd_n;
  logic       win_q, win_n;
  logic       done_q, txv_q, acc_q;
  logic [7:0] rd_q, txb_q;

  uwdf_pkg::ring_st_t      rst_s [uwdf_pkg::RINGS];
  logic [7:0]              rdat  [uwdf_pkg::RINGS];
  logic [uwdf_pkg::RINGS-1:0] push, pop, clr;

  logic       exec;
  logic [7:0] rd, txb;
  logic       txv, acc, do_iid;
  logic [2:0] n;
  logic [7:0] lsr, nw, old;
  logic [2:0] iid;

  assign exec = (st_q == ST_EXEC);
  assign busy = exec;
  assign n    = addr_q[2:0];

  for (genvar g = 0; g < uwdf_pkg::RINGS; g++) begin : g_ring
    localparam int D  = DEPTHS[g];
    localparam int PW = $clog2(D);
    logic [PW-1:0] head_q, tail_q;
    logic [PW:0]   used, free;

    function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
      return (p == PW'(D - 1)) ? '0 : p + PW'(1);
    endfunction

    always_comb begin
      used = {1'b0, head_q} - {1'b0, tail_q};
      if (head_q < tail_q) used = used + (PW+1)'(D);
      free = (PW+1)'(D - 1) - used;
      rst_s[g].full     = (nxt(head_q) == tail_q);
      rst_s[g].empty    = (head_q == tail_q);
      rst_s[g].afull    = (used == (PW+1)'(D - 2));
      rst_s[g].multi    = (used > (PW+1)'(1));
      rst_s[g].used_sat = (32'(used) > 32'(uwdf_pkg::COUNT_SAT)) ? uwdf_pkg::COUNT_SAT
                                                                  : 8'(used);
      rst_s[g].free_sat = (32'(free) > 32'(uwdf_pkg::COUNT_SAT)) ? uwdf_pkg::COUNT_SAT
                                                                  : 8'(free);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        head_q <= '0;
        tail_q <= '0;
      end else if (clr[g]) begin
        head_q <= '0;
        tail_q <= '0;
      end else begin
        if (push[g]) head_q <= nxt(head_q);
        if (pop[g])  tail_q <= nxt(tail_q);
      end
    end

    uwdf_ram #(.WIDTH(8), .DEPTH(D)) u_ram (
      .clk_i   (clk_i),
      .we_i    (push[g]),
      .waddr_i (head_q),
      .wdata_i (data_q),
      .raddr_i (tail_q),
      .rdata_o (rdat[g])
    );
  end

  always_comb begin
    rd     = uwdf_pkg::NO_ANSWER;
    txv    = 1'b0;
    txb    = 8'h00;
    acc    = 1'b0;
    push   = '0;
    pop    = '0;
    clr    = '0;
    uart_n = uart_q;
    dll_n  = dll_q;
    api_n  = api_q;
    cmd_n  = cmd_q;
    win_n  = win_q;
    do_iid = 1'b0;
    old    = uart_q[uwdf_pkg::UART_MSR];
    nw     = 8'h00;
    if (exec) begin
      case (op_q)
        uwdf_pkg::OP_BUS_RD: begin
          if (addr_q >= uwdf_pkg::ADDR_UART) begin
            if (n < 3'd2 && (uart_q[uwdf_pkg::UART_LCR] & uwdf_pkg::LCR_DLAB) != 8'h00) begin
              rd = dll_q[n[0]];
            end else begin
              rd = uart_q[n];
              if (n == uwdf_pkg::UART_RBR) begin
                if (!rst_s[uwdf_pkg::RING_SRX].empty) begin
                  pop[uwdf_pkg::RING_SRX] = 1'b1;
                  rd = rdat[uwdf_pkg::RING_SRX];
                  uart_n[uwdf_pkg::UART_RBR] = rdat[uwdf_pkg::RING_SRX];
                end
                uart_n[uwdf_pkg::UART_LSR][0] = rst_s[uwdf_pkg::RING_SRX].multi;
                do_iid = 1'b1;
              end else if (n == uwdf_pkg::UART_LSR) begin
                uart_n[uwdf_pkg::UART_LSR] = uart_q[uwdf_pkg::UART_LSR] & ~uwdf_pkg::LSR_ERR;
                do_iid = 1'b1;
              end else if (n == uwdf_pkg::UART_MSR) begin
                nw = (old & ~(uwdf_pkg::MSR_CTS | uwdf_pkg::MSR_DCTS))
                   | (cts_q ? uwdf_pkg::MSR_CTS : 8'h00);
                nw = nw | (((old ^ nw) & uwdf_pkg::MSR_CTS) >> 4);
                uart_n[uwdf_pkg::UART_MSR] = nw;
                rd = nw;
              end
            end
          end else if (addr_q <= uwdf_pkg::ADDR_WIN_LAST) begin
            if (win_q) begin
              if (api_q == 3'd1 && !rst_s[uwdf_pkg::RING_WRX].empty) begin
                pop[uwdf_pkg::RING_WRX] = 1'b1;
                rd = rdat[uwdf_pkg::RING_WRX];
              end
            end else if (api_q != 3'd0 && !rst_s[uwdf_pkg::RING_SRX].empty) begin
              pop[uwdf_pkg::RING_SRX] = 1'b1;
              rd = rdat[uwdf_pkg::RING_SRX];
            end
          end else if (addr_q == uwdf_pkg::ADDR_WRX_USED ||
                       addr_q == uwdf_pkg::ADDR_WTX_FREE) begin
            if (api_q == 3'd1) begin
              rd = (addr_q == uwdf_pkg::ADDR_WRX_USED) ? rst_s[uwdf_pkg::RING_WRX].used_sat
                                                       : rst_s[uwdf_pkg::RING_WTX].free_sat;
              win_n = 1'b1;
            end
          end else if (addr_q == uwdf_pkg::ADDR_SRX_USED ||
                       addr_q == uwdf_pkg::ADDR_STX_FREE) begin
            if (api_q != 3'd0) begin
              rd = (addr_q == uwdf_pkg::ADDR_SRX_USED) ? rst_s[uwdf_pkg::RING_SRX].used_sat
                                                       : rst_s[uwdf_pkg::RING_STX].free_sat;
              win_n = 1'b0;
            end
          end else if (addr_q == uwdf_pkg::ADDR_CMD) begin
            if (api_q != 3'd0) rd = cmd_q;
          end
        end
        uwdf_pkg::OP_BUS_WR: begin
          if (addr_q >= uwdf_pkg::ADDR_UART) begin
            if (n == uwdf_pkg::UART_LSR || n == uwdf_pkg::UART_MSR) begin
              rd = uwdf_pkg::NO_ANSWER;
            end else if (n < 3'd2 &&
                         (uart_q[uwdf_pkg::UART_LCR] & uwdf_pkg::LCR_DLAB) != 8'h00) begin
              dll_n[n[0]] = data_q;
            end else if (n == uwdf_pkg::UART_RBR) begin
              uart_n[uwdf_pkg::UART_LSR] = uart_q[uwdf_pkg::UART_LSR] & ~uwdf_pkg::LSR_THRE;
              if (!rst_s[uwdf_pkg::RING_STX].full) begin
                push[uwdf_pkg::RING_STX] = 1'b1;
                if (!rst_s[uwdf_pkg::RING_STX].afull)
                  uart_n[uwdf_pkg::UART_LSR] = uart_n[uwdf_pkg::UART_LSR] | uwdf_pkg::LSR_THRE;
              end
              do_iid = 1'b1;
            end else if (n == uwdf_pkg::UART_IIR) begin
              clr[uwdf_pkg::RING_SRX] = data_q[1];
              clr[uwdf_pkg::RING_STX] = data_q[2];
            end else begin
              uart_n[n] = data_q;
            end
          end else if (addr_q == uwdf_pkg::ADDR_CMD) begin
            if ((data_q & uwdf_pkg::CMD_SET_MASK) == uwdf_pkg::CMD_SET_LYR) begin
              api_n = (data_q[2:0] > 3'(API_LAYERS)) ? 3'd0 : data_q[2:0];
              cmd_n = 8'h00;
            end else if (api_q != 3'd0) begin
              if (data_q == uwdf_pkg::CMD_QUERY) begin
                cmd_n = 8'(API_LAYERS);
              end else if ((data_q & uwdf_pkg::CMD_CLR_MASK) == uwdf_pkg::CMD_CLR_WL) begin
                clr[uwdf_pkg::RING_WRX] = data_q[0];
                clr[uwdf_pkg::RING_WTX] = data_q[1];
              end else if ((data_q & uwdf_pkg::CMD_CLR_MASK) == uwdf_pkg::CMD_CLR_SER) begin
                clr[uwdf_pkg::RING_SRX] = data_q[0];
                clr[uwdf_pkg::RING_STX] = data_q[1];
              end
            end
          end else if (addr_q <= uwdf_pkg::ADDR_WIN_LAST) begin
            if (win_q) begin
              if (api_q == 3'd1 && !rst_s[uwdf_pkg::RING_WTX].full)
                push[uwdf_pkg::RING_WTX] = 1'b1;
            end else if (api_q != 3'd0) begin
              uart_n[uwdf_pkg::UART_LSR] = uart_q[uwdf_pkg::UART_LSR] & ~uwdf_pkg::LSR_THRE;
              if (!rst_s[uwdf_pkg::RING_STX].full) begin
                push[uwdf_pkg::RING_STX] = 1'b1;
                if (!rst_s[uwdf_pkg::RING_STX].afull)
                  uart_n[uwdf_pkg::UART_LSR] = uart_n[uwdf_pkg::UART_LSR] | uwdf_pkg::LSR_THRE;
              end
            end
          end
        end
        uwdf_pkg::OP_WRX_PUT, uwdf_pkg::OP_SRX_PUT,
        uwdf_pkg::OP_WTX_GET, uwdf_pkg::OP_STX_GET: begin
          case (op_q)
            uwdf_pkg::OP_WRX_PUT: begin
              acc = !rst_s[uwdf_pkg::RING_WRX].full;
              push[uwdf_pkg::RING_WRX] = acc;
            end
            uwdf_pkg::OP_SRX_PUT: begin
              acc = !rst_s[uwdf_pkg::RING_SRX].full;
              push[uwdf_pkg::RING_SRX] = acc;
            end
            uwdf_pkg::OP_WTX_GET: begin
              txv = !rst_s[uwdf_pkg::RING_WTX].empty;
              pop[uwdf_pkg::RING_WTX] = txv;
              txb = txv ? rdat[uwdf_pkg::RING_WTX] : 8'h00;
            end
            default: begin
              txv = !rst_s[uwdf_pkg::RING_STX].empty;
              pop[uwdf_pkg::RING_STX] = txv;
              txb = txv ? rdat[uwdf_pkg::RING_STX] : 8'h00;
            end
          endcase
          if (op_q == uwdf_pkg::OP_STX_GET || !rst_s[uwdf_pkg::RING_STX].full)
            uart_n[uwdf_pkg::UART_LSR] = uart_n[uwdf_pkg::UART_LSR] | uwdf_pkg::LSR_THRE;
          if (op_q == uwdf_pkg::OP_SRX_PUT || !rst_s[uwdf_pkg::RING_SRX].empty)
            uart_n[uwdf_pkg::UART_LSR] = uart_n[uwdf_pkg::UART_LSR] | uwdf_pkg::LSR_DR;
          do_iid = 1'b1;
        end
        default: begin
          rd = uwdf_pkg::NO_ANSWER;
        end
      endcase
    end
    lsr = uart_n[uwdf_pkg::UART_LSR];
    if ((lsr & uwdf_pkg::LSR_INT_SRC) != 8'h00) iid = uwdf_pkg::IID_LINE;
    else if (lsr[0])                             iid = uwdf_pkg::IID_DATA;
    else if (lsr[5])                             iid = uwdf_pkg::IID_THRE;
    else                                         iid = uwdf_pkg::IID_NONE;
    if (do_iid) begin
      uart_n[uwdf_pkg::UART_MSR][4] = lsr[5];
      uart_n[uwdf_pkg::UART_IIR]    = {5'b0, iid};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      done_q  <= 1'b0;
      txv_q   <= 1'b0;
      acc_q   <= 1'b0;
      rd_q    <= uwdf_pkg::NO_ANSWER;
      txb_q   <= 8'h00;
      uart_q  <= '{default: 8'h00};
      dll_q   <= '{default: 8'h00};
      api_q   <= 3'd0;
      cmd_q   <= uwdf_pkg::NO_ANSWER;
      win_q   <= 1'b0;
      op_q    <= 3'd0;
      addr_q  <= 8'h00;
      data_q  <= 8'h00;
      cts_q   <= 1'b0;
    end else begin
      done_q <= exec;
      case (st_q)
        ST_IDLE: begin
          if (start) begin
            st_q   <= ST_EXEC;
            op_q   <= op_i;
            addr_q <= reg_addr_i;
            data_q <= data_in_i;
            cts_q  <= cts_level_i;
          end
        end
        ST_EXEC: begin
          st_q   <= ST_IDLE;
          rd_q   <= rd;
          txv_q  <= txv;
          txb_q  <= txb;
          acc_q  <= acc;
          uart_q <= uart_n;
          dll_q  <= dll_n;
          api_q  <= api_n;
          cmd_q  <= cmd_n;
          win_q  <= win_n;
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign done_o          = done_q;
  assign read_data_o     = rd_q;
  assign tx_valid_o      = txv_q;
  assign tx_byte_o       = txb_q;
  assign byte_accepted_o = acc_q;
  assign interrupt_id_o  = uart_q[uwdf_pkg::UART_IIR][2:0];

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("request not executed");
  a_single_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy && done_o) else $error("execute cycle not followed by result");
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)) else $error("result without request");
  a_tx_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(tx_valid_o) || $rose(byte_accepted_o)) |-> done_o)
    else $error("flag outside result");
  a_push_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push != '0 || pop != '0 || clr != '0) |-> busy) else $error("ring update while idle");

endmodule

### test/uart_with_dual_fifo_bridge_registers_top_tb.sv
// Testbench for the UART register block with four byte rings: directed and
// random bus and line requests, checked against an in-bench predictor.
// Depends on uwdf_pkg and uart_with_dual_fifo_bridge_registers_top.
`timescale 1ns / 1ps

module uart_with_dual_fifo_bridge_registers_top_tb;
  import uwdf_pkg::*;

  typedef struct {
    logic [2:0] op;
    logic [7:0] addr;
    logic [7:0] data;
    logic       cts;
  } req_t;

  typedef struct {
    logic [7:0] rd;
    logic       txv;
    logic [7:0] txb;
    logic       acc;
    logic [2:0] iid;
  } res_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [2:0] op_i = '0;
  logic [7:0] reg_addr_i = '0;
  logic [7:0] data_in_i = '0;
  logic       cts_level_i = 1'b0;
  logic       done_o;
  logic [7:0] read_data_o;
  logic       tx_valid_o;
  logic [7:0] tx_byte_o;
  logic       byte_accepted_o;
  logic [2:0] interrupt_id_o;

  uart_with_dual_fifo_bridge_registers_top dut (.*);

  initial forever #5 clk_i = ~clk_i;

  req_t  stim_q[$];
  res_t  pending_results[$];
  int    errors = 0;
  int    sent_cnt = 0;
  int    taken_cnt = 0;
  int    gap = 0;

  // predictor state
  logic [7:0] ring_mem[RINGS][256];
  logic [7:0] head[RINGS];
  logic [7:0] tail[RINGS];
  logic [7:0] urf[8];
  logic [7:0] dl[2];
  logic [2:0] layer;
  logic [7:0] cmd_res;
  logic       win_wl;

  function automatic logic rfull(int r);
    return 8'(head[r] + 8'd1) == tail[r];
  endfunction

  function automatic logic rempty(int r);
    return head[r] == tail[r];
  endfunction

  function automatic logic [7:0] sat(logic [7:0] n);
    return (n > COUNT_SAT) ? COUNT_SAT : n;
  endfunction

  function automatic logic rpush(int r, logic [7:0] v);
    if (rfull(r)) return 1'b0;
    ring_mem[r][head[r]] = v;
    head[r] = head[r] + 8'd1;
    return 1'b1;
  endfunction

  function automatic logic rpop(int r, output logic [7:0] v);
    v = '0;
    if (rempty(r)) return 1'b0;
    v = ring_mem[r][tail[r]];
    tail[r] = tail[r] + 8'd1;
    return 1'b1;
  endfunction

  function automatic void rclear(int r);
    head[r] = '0;
    tail[r] = '0;
  endfunction

  function automatic void update_iid();
    logic [7:0] lsr;
    logic [2:0] m;
    lsr = urf[UART_LSR];
    m = {2'b0, lsr[0]};
    urf[UART_MSR] &= ~MSR_CTS;
    if (lsr & 8'h20) begin
      m |= 3'd2;
      urf[UART_MSR] |= MSR_CTS;
    end
    if (lsr & LSR_INT_SRC) m |= 3'd4;
    if (m[2]) urf[UART_IIR] = 8'(IID_LINE);
    else if (m[0]) urf[UART_IIR] = 8'(IID_DATA);
    else if (m[1]) urf[UART_IIR] = 8'(IID_THRE);
    else urf[UART_IIR] = 8'(IID_NONE);
  endfunction

  function automatic void stx_push(logic [7:0] v);
    logic ok;
    urf[UART_LSR] &= ~LSR_THRE;
    ok = rpush(RING_STX, v);
    if (ok && !rfull(RING_STX)) urf[UART_LSR] |= LSR_THRE;
  endfunction

  function automatic void line_refresh();
    if (!rfull(RING_STX)) urf[UART_LSR] |= LSR_THRE;
    if (!rempty(RING_SRX)) urf[UART_LSR] |= LSR_DR;
    update_iid();
  endfunction

  function automatic void bus_wr(logic [7:0] a, logic [7:0] v);
    logic [2:0] n;
    n = a[2:0];
    if (a >= ADDR_UART) begin
      if (n == UART_LSR || n == UART_MSR) return;
      if (n < 3'd2 && (urf[UART_LCR] & LCR_DLAB)) begin
        dl[n[0]] = v;
        return;
      end
      if (n == UART_RBR) begin
        stx_push(v);
        update_iid();
        return;
      end
      if (n == UART_IIR) begin
        if (v[1]) rclear(RING_SRX);
        if (v[2]) rclear(RING_STX);
        return;
      end
      urf[n] = v;
    end else if (a == ADDR_CMD) begin
      if ((v & CMD_SET_MASK) == CMD_SET_LYR) begin
        layer = v[2:0];
        if (layer > 3'd1) layer = '0;
        cmd_res = '0;
      end else if (layer != 0) begin
        if (v == CMD_QUERY) cmd_res = 8'd1;
        else if ((v & CMD_CLR_MASK) == CMD_CLR_WL) begin
          if (v[0]) rclear(RING_WRX);
          if (v[1]) rclear(RING_WTX);
        end else if ((v & CMD_CLR_MASK) == CMD_CLR_SER) begin
          if (v[0]) rclear(RING_SRX);
          if (v[1]) rclear(RING_STX);
        end
      end
    end else if (a <= ADDR_WIN_LAST) begin
      if (win_wl) begin
        if (layer == 3'd1) void'(rpush(RING_WTX, v));
      end else if (layer != 0) begin
        stx_push(v);
      end
    end
  endfunction

  function automatic logic [7:0] bus_rd(logic [7:0] a, logic cts);
    logic [7:0] r, b, old, nw;
    logic [2:0] n;
    r = NO_ANSWER;
    n = a[2:0];
    if (a >= ADDR_UART) begin
      if (n < 3'd2 && (urf[UART_LCR] & LCR_DLAB)) return dl[n[0]];
      r = urf[n];
      if (n == UART_RBR) begin
        if (rpop(RING_SRX, b)) begin
          urf[UART_RBR] = b;
          r = b;
        end
        if (!rempty(RING_SRX)) urf[UART_LSR] |= LSR_DR;
        else urf[UART_LSR] &= ~LSR_DR;
        update_iid();
      end else if (n == UART_LSR) begin
        urf[UART_LSR] &= ~LSR_ERR;
        update_iid();
      end else if (n == UART_MSR) begin
        old = urf[UART_MSR];
        nw = (old & ~8'h11) | (cts ? MSR_CTS : 8'h00);
        nw |= ((old ^ nw) & MSR_CTS) >> 4;
        urf[UART_MSR] = nw;
        r = nw;
      end
    end else if (a <= ADDR_WIN_LAST) begin
      if (win_wl) begin
        if (layer == 3'd1 && rpop(RING_WRX, b)) r = b;
      end else if (layer != 0 && rpop(RING_SRX, b)) begin
        r = b;
      end
    end else if (a == ADDR_WRX_USED || a == ADDR_WTX_FREE) begin
      if (layer == 3'd1) begin
        r = (a == ADDR_WRX_USED) ? sat(head[RING_WRX] - tail[RING_WRX])
                                 : sat(8'd255 - 8'(head[RING_WTX] - tail[RING_WTX]));
        win_wl = 1'b1;
      end
    end else if (a == ADDR_SRX_USED || a == ADDR_STX_FREE) begin
      if (layer != 0) begin
        r = (a == ADDR_SRX_USED) ? sat(head[RING_SRX] - tail[RING_SRX])
                                 : sat(8'd255 - 8'(head[RING_STX] - tail[RING_STX]));
        win_wl = 1'b0;
      end
    end else if (a == ADDR_CMD) begin
      if (layer != 0) r = cmd_res;
    end
    return r;
  endfunction

  function automatic res_t uart_step(req_t q);
    res_t o;
    logic [7:0] b;
    o.rd = NO_ANSWER;
    o.txv = 1'b0;
    o.txb = '0;
    o.acc = 1'b0;
    case (q.op)
      OP_BUS_RD:  o.rd = bus_rd(q.addr, q.cts);
      OP_BUS_WR:  bus_wr(q.addr, q.data);
      OP_WRX_PUT: begin o.acc = rpush(RING_WRX, q.data); line_refresh(); end
      OP_SRX_PUT: begin o.acc = rpush(RING_SRX, q.data); line_refresh(); end
      OP_WTX_GET: begin
        if (rpop(RING_WTX, b)) begin o.txv = 1'b1; o.txb = b; end
        line_refresh();
      end
      OP_STX_GET: begin
        if (rpop(RING_STX, b)) begin o.txv = 1'b1; o.txb = b; end
        line_refresh();
      end
      default: ;
    endcase
    o.iid = urf[UART_IIR][2:0];
    return o;
  endfunction

  initial begin
    for (int i = 0; i < RINGS; i++) rclear(i);
    for (int i = 0; i < 8; i++) urf[i] = '0;
    dl[0] = '0;
    dl[1] = '0;
    layer = '0;
    cmd_res = NO_ANSWER;
    win_wl = 1'b0;
  end

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && !(start && sent_cnt != taken_cnt)) begin
      if (gap > 0) begin
        gap <= gap - 1;
        start <= 1'b0;
      end else if (stim_q.size() > 0) begin
        req_t q;
        int r;
        q = stim_q.pop_front();
        op_i <= q.op;
        reg_addr_i <= q.addr;
        data_in_i <= q.data;
        cts_level_i <= q.cts;
        start <= 1'b1;
        sent_cnt <= sent_cnt + 1;
        r = $urandom_range(0, 99);
        gap <= (r < 45) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) begin
      req_t q;
      q.op = op_i;
      q.addr = reg_addr_i;
      q.data = data_in_i;
      q.cts = cts_level_i;
      pending_results.push_back(uart_step(q));
      taken_cnt <= taken_cnt + 1;
    end
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result rd=%h", $time, read_data_o);
        errors++;
      end else begin
        res_t e;
        e = pending_results.pop_front();
        if (e.rd !== read_data_o) begin
          $display("%0t: read_data exp %h got %h", $time, e.rd, read_data_o);
          errors++;
        end
        if (e.txv !== tx_valid_o) begin
          $display("%0t: tx_valid exp %h got %h", $time, e.txv, tx_valid_o);
          errors++;
        end
        if (e.txb !== tx_byte_o) begin
          $display("%0t: tx_byte exp %h got %h", $time, e.txb, tx_byte_o);
          errors++;
        end
        if (e.acc !== byte_accepted_o) begin
          $display("%0t: byte_accepted exp %h got %h", $time, e.acc, byte_accepted_o);
          errors++;
        end
        if (e.iid !== interrupt_id_o) begin
          $display("%0t: interrupt_id exp %h got %h", $time, e.iid, interrupt_id_o);
          errors++;
        end
      end
    end
  end

  task automatic add(logic [2:0] op, logic [7:0] a, logic [7:0] d, logic c = 1'b0);
    req_t q;
    q.op = op;
    q.addr = a;
    q.data = d;
    q.cts = c;
    stim_q.push_back(q);
  endtask

  function automatic logic [7:0] pick_addr();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 8'($urandom_range(0, 191));
    if (r < 45) return 8'($urandom_range(ADDR_WRX_USED, ADDR_STX_FREE));
    if (r < 55) return ADDR_CMD;
    if (r < 92) return 8'($urandom_range(ADDR_UART, 255));
    return 8'($urandom_range(192, 247));
  endfunction

  function automatic logic [7:0] pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return CMD_SET_LYR | 8'd1;
    if (r < 50) return CMD_SET_LYR | 8'($urandom_range(0, 7));
    if (r < 60) return CMD_QUERY;
    if (r < 80) return 8'($urandom_range(0, 7));
    return 8'($urandom);
  endfunction

  task automatic add_random();
    int r;
    logic [7:0] a, d;
    r = $urandom_range(0, 99);
    d = 8'($urandom);
    if (r < 12) add(OP_WRX_PUT, 8'($urandom), d);
    else if (r < 24) add(OP_SRX_PUT, 8'($urandom), d);
    else if (r < 31) add(OP_WTX_GET, 8'($urandom), d);
    else if (r < 38) add(OP_STX_GET, 8'($urandom), d);
    else if (r < 66) add(OP_BUS_RD, pick_addr(), d, 1'($urandom));
    else if (r < 97) begin
      a = pick_addr();
      if (a == ADDR_CMD) d = pick_cmd();
      else if (a == (ADDR_UART | 8'(UART_IIR)) && $urandom_range(0, 3) != 0) d = d & 8'hF9;
      else if (a == (ADDR_UART | 8'(UART_LCR)) && $urandom_range(0, 2) != 0) d = d & ~LCR_DLAB;
      add(OP_BUS_WR, a, d);
    end else add(3'($urandom_range(6, 7)), 8'($urandom), d, 1'($urandom));
  endtask

  initial begin
    // directed
    add(OP_BUS_RD, ADDR_UART | 8'(UART_IIR), 8'h00);
    add(OP_BUS_RD, ADDR_CMD, 8'h00);
    add(OP_BUS_WR, ADDR_CMD, CMD_SET_LYR | 8'd1);
    add(OP_BUS_RD, ADDR_CMD, 8'h00);
    add(OP_BUS_WR, ADDR_CMD, CMD_QUERY);
    add(OP_BUS_RD, ADDR_CMD, 8'h00);
    add(OP_BUS_WR, ADDR_UART | 8'(UART_LCR), 8'h83);
    add(OP_BUS_WR, ADDR_UART, 8'h12);
    add(OP_BUS_WR, ADDR_UART | 8'd1, 8'hFF);
    add(OP_BUS_RD, ADDR_UART, 8'h00);
    add(OP_BUS_RD, ADDR_UART | 8'd1, 8'h00);
    add(OP_BUS_WR, ADDR_UART | 8'(UART_LCR), 8'h03);
    add(OP_BUS_WR, ADDR_UART, 8'hA5);
    add(OP_STX_GET, 8'h00, 8'h00);
    add(OP_WTX_GET, 8'h00, 8'h00);
    add(OP_SRX_PUT, 8'h00, 8'h00);
    add(OP_SRX_PUT, 8'hFF, 8'hFF);
    add(OP_BUS_RD, ADDR_UART, 8'h00);
    add(OP_BUS_RD, ADDR_UART | 8'(UART_LSR), 8'h00);
    add(OP_BUS_RD, ADDR_UART | 8'(UART_MSR), 8'h00, 1'b1);
    add(OP_BUS_RD, ADDR_UART | 8'(UART_MSR), 8'h00, 1'b0);
    add(OP_BUS_RD, ADDR_SRX_USED, 8'h00);
    add(OP_BUS_RD, ADDR_WIN_LAST, 8'h00);
    add(OP_BUS_RD, ADDR_WRX_USED, 8'h00);
    add(OP_BUS_WR, 8'h10, 8'h5A);
    add(OP_WTX_GET, 8'h00, 8'h00);
    add(OP_BUS_WR, ADDR_UART | 8'(UART_IIR), 8'h06);
    add(3'd7, 8'hFF, 8'hFF, 1'b1);
    add(OP_BUS_RD, 8'hD0, 8'h00);
    // random, with fill bursts that drive each ring to full
    for (int ph = 0; ph < 4; ph++) begin
      add(OP_BUS_WR, ADDR_CMD, CMD_SET_LYR | 8'd1);
      add(OP_BUS_WR, ADDR_UART | 8'(UART_LCR), 8'h03);
      for (int i = 0; i < 5; i++) add_random();
      case (ph)
        0: for (int i = 0; i < 256; i++) add(OP_SRX_PUT, 8'($urandom), 8'($urandom));
        1: for (int i = 0; i < 256; i++) add(OP_BUS_WR, ADDR_UART, 8'($urandom));
        2: for (int i = 0; i < 256; i++) add(OP_WRX_PUT, 8'($urandom), 8'($urandom));
        default: begin
          add(OP_BUS_RD, ADDR_WTX_FREE, 8'h00);
          for (int i = 0; i < 256; i++) add(OP_BUS_WR, 8'($urandom_range(0, 191)), 8'($urandom));
        end
      endcase
      add(OP_BUS_RD, ADDR_WRX_USED, 8'h00);
      add(OP_BUS_RD, ADDR_WTX_FREE, 8'h00);
      add(OP_BUS_RD, ADDR_SRX_USED, 8'h00);
      add(OP_BUS_RD, ADDR_STX_FREE, 8'h00);
      for (int i = 0; i < 3; i++) add_random();
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_q.size() == 0 && sent_cnt == taken_cnt && pending_results.size() == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0)
      $display("uart_with_dual_fifo_bridge_registers_top verification clean");
    else
      $display("uart_with_dual_fifo_bridge_registers_top verification failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("uart_with_dual_fifo_bridge_registers_top verification failed");
    $finish;
  end

endmodule
